### sv/serpentine_grid_cell_index_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the serpentine grid cell index block
// ----------------------------------------------------------------------------
`ifndef SERPENTINE_GRID_CELL_INDEX_CORE_MACROS_SVH
`define SERPENTINE_GRID_CELL_INDEX_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define SGCI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgci check failed");

// next-cycle implication, quiet during reset
`define SGCI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgci check failed");

`endif

### sv/sgci_pkg.sv
// ----------------------------------------------------------------------------
// sgci_pkg
// types, constants and helpers shared by the serpentine grid index pipeline
// ----------------------------------------------------------------------------
package sgci_pkg;

	localparam int MAX_DIM   = 255;
	localparam int DIM_W     = 8;
	localparam int STEP_W    = 16;
	localparam int CELL_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int Q_W       = DIM_W;
	localparam int STAGES    = 5;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

	typedef enum logic [1:0] {
		CORNER_TL = 2'd0,
		CORNER_TR = 2'd1,
		CORNER_BR = 2'd2,
		CORNER_BL = 2'd3
	} corner_t;

	typedef struct packed {
		corner_t            start_corner;
		logic               column_wise;
		logic [STEP_W-1:0]  step_count;
	} req_t;

	typedef struct packed {
		logic [CELL_W-1:0]  cell_number;
		logic               step_invalid;
	} rsp_t;

	typedef struct packed {
		logic [DIM_W-1:0]   row_count;
		logic [DIM_W-1:0]   col_count;
		logic [CELL_W-1:0]  total;
	} cfg_t;

	typedef struct packed {
		logic [STAGES-1:0]  en;
	} pipe_ctl_t;

	typedef struct packed {
		corner_t            corner;
		logic               column_wise;
		logic               zero;
		logic [STEP_W-1:0]  k;
	} s1_t;

	typedef struct packed {
		corner_t            corner;
		logic               column_wise;
		logic               invalid;
		logic [DIM_W-1:0]   len;
		logic [STEP_W-1:0]  rem;
		logic [Q_W-1:0]     q;
	} div_t;

	typedef struct packed {
		logic               invalid;
		logic [DIM_W-1:0]   r;
		logic [DIM_W-1:0]   c;
	} pos_t;

	typedef struct packed {
		logic               qbit;
		logic [STEP_W-1:0]  rem;
	} div_res_t;

	// one restoring step: try to take len << sh off the partial remainder
	function automatic div_res_t div_step(logic [STEP_W-1:0] rem, logic [DIM_W-1:0] len,
		int unsigned sh);
		logic [STEP_W-1:0] d;
		div_res_t          res;
		d        = {{(STEP_W-DIM_W){1'b0}}, len} << sh;
		res.qbit = (rem >= d);
		res.rem  = res.qbit ? (rem - d) : rem;
		return res;
	endfunction

	// written dimension saturates at the largest supported size
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] m;
		m = v;
		if (int'(v) > MAX_DIM) begin
			m = DIM_W'(MAX_DIM);
		end
		return m;
	endfunction

endpackage

### sv/serpentine_grid_cell_index_core.sv
// ----------------------------------------------------------------------------
// serpentine_grid_cell_index_core
// maps a serpentine walk position on a configured grid to a row-major cell
// ----------------------------------------------------------------------------
// usage:
//   cfg_we/cfg_addr/cfg_wdata write row count (index 0) or column count
//   (index 1); write only while no word is in flight.
//   req carries start corner, walk direction and 1-based step; rsp returns
//   the cell number and an invalid flag (step zero or past the grid).
//   both channels are valid/ready; one word is taken per cycle while req_ready is high.
// pipeline: from request accept to response valid a word passes the
//   capture stage (loaded at the accepting edge), two divider stages
//   (4 quotient bits each), the mapping stage and the multiply stage.
// throughput: one word per cycle, sustained while rsp_ready stays high.
// reset: all stage valids clear, grid returns to 1 x 1.
// stall: each stage holds while the next one is full and stalled, so
//   empty stages keep filling; req_ready drops only when all are full.
// ----------------------------------------------------------------------------
module serpentine_grid_cell_index_core
	import sgci_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [DIM_W-1:0]     cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp
);

	cfg_t              cfg;
	pipe_ctl_t         ctl;
	div_t              div_s3;
	logic [STAGES-1:0] valid_q;

	always_comb begin
		ctl.en[STAGES-1] = !valid_q[STAGES-1] || rsp_ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			ctl.en[i] = !valid_q[i] || ctl.en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.en[0]) begin
				valid_q[0] <= req_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (ctl.en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	sgci_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sgci_div u_div (
		.clk    (clk),
		.req    (req),
		.cfg    (cfg),
		.ctl    (ctl),
		.div_s3 (div_s3)
	);

	sgci_map u_map (
		.clk    (clk),
		.div_s3 (div_s3),
		.cfg    (cfg),
		.ctl    (ctl),
		.rsp    (rsp)
	);

	assign req_ready = ctl.en[0];
	assign rsp_valid = valid_q[STAGES-1];

endmodule

### sv/sgci_cfg.sv
// ----------------------------------------------------------------------------
// sgci_cfg
// grid size registers and the registered cell total
// ----------------------------------------------------------------------------
module sgci_cfg
	import sgci_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [DIM_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	logic [DIM_W-1:0]  row_q;
	logic [DIM_W-1:0]  col_q;
	logic [CELL_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= DIM_W'(1);
			col_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ROW_COUNT: row_q <= clamp_dim(cfg_wdata);
				REG_COL_COUNT: col_q <= clamp_dim(cfg_wdata);
				default: ;
			endcase
		end
	end

	// total follows the size registers in the next cycle; it is first read one stage after accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= CELL_W'(1);
		end else begin
			total_q <= CELL_W'(row_q * col_q);
		end
	end

	assign cfg.row_count = row_q;
	assign cfg.col_count = col_q;
	assign cfg.total     = total_q;

endmodule

### sv/sgci_div.sv
// ----------------------------------------------------------------------------
// sgci_div
// input capture, range check and two-stage radix-2 divide by line length
// ----------------------------------------------------------------------------
module sgci_div
	import sgci_pkg::*;
(
	input  logic      clk,
	input  req_t      req,
	input  cfg_t      cfg,
	input  pipe_ctl_t ctl,
	output div_t      div_s3
);

	s1_t      s1_s1;
	div_t     s2_s2;
	div_t     s3_s3;
	div_t     s2_d;
	div_t     s3_d;
	div_res_t st2;
	div_res_t st3;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			s1_s1.corner      <= req.start_corner;
			s1_s1.column_wise <= req.column_wise;
			s1_s1.zero        <= (req.step_count == '0);
			s1_s1.k           <= req.step_count - STEP_W'(1);
		end
	end

	// upper quotient bits; the quotient stays below 256 for any valid step
	always_comb begin
		s2_d.corner      = s1_s1.corner;
		s2_d.column_wise = s1_s1.column_wise;
		s2_d.invalid     = s1_s1.zero || (s1_s1.k >= cfg.total);
		s2_d.len         = s1_s1.column_wise ? cfg.row_count : cfg.col_count;
		s2_d.rem         = s1_s1.k;
		s2_d.q           = '0;
		for (int i = Q_W - 1; i >= Q_W / 2; i--) begin
			st2           = div_step(s2_d.rem, s2_d.len, i);
			s2_d.rem      = st2.rem;
			s2_d.q[i]     = st2.qbit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			s2_s2 <= s2_d;
		end
	end

	always_comb begin
		s3_d = s2_s2;
		for (int i = Q_W / 2 - 1; i >= 0; i--) begin
			st3           = div_step(s3_d.rem, s3_d.len, i);
			s3_d.rem      = st3.rem;
			s3_d.q[i]     = st3.qbit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			s3_s3 <= s3_d;
		end
	end

	assign div_s3 = s3_s3;

endmodule

### sv/sgci_map.sv
// ----------------------------------------------------------------------------
// sgci_map
// serpentine mirror and corner mapping, then row-major cell number
// ----------------------------------------------------------------------------
module sgci_map
	import sgci_pkg::*;
(
	input  logic      clk,
	input  div_t      div_s3,
	input  cfg_t      cfg,
	input  pipe_ctl_t ctl,
	output rsp_t      rsp
);

	pos_t             pos_s4;
	pos_t             pos_d;
	rsp_t             rsp_s5;
	logic [DIM_W-1:0] line;
	logic [DIM_W-1:0] pos;
	logic [DIM_W-1:0] row_m1;
	logic [DIM_W-1:0] col_m1;
	logic             flip_r;
	logic             flip_c;
	logic [CELL_W-1:0] cell_num;

	always_comb begin
		line   = div_s3.q;
		pos    = div_s3.rem[DIM_W-1:0];
		row_m1 = cfg.row_count - DIM_W'(1);
		col_m1 = cfg.col_count - DIM_W'(1);
		flip_r = (div_s3.corner == CORNER_BR) || (div_s3.corner == CORNER_BL);
		flip_c = (div_s3.corner == CORNER_TR) || (div_s3.corner == CORNER_BR);
		// odd lines run backwards
		if (line[0]) begin
			pos = div_s3.len - DIM_W'(1) - pos;
		end
		pos_d.invalid = div_s3.invalid;
		if (!div_s3.column_wise) begin
			pos_d.r = flip_r ? (row_m1 - line) : line;
			pos_d.c = flip_c ? (col_m1 - pos) : pos;
		end else begin
			pos_d.c = flip_c ? (col_m1 - line) : line;
			pos_d.r = flip_r ? (row_m1 - pos) : pos;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			pos_s4 <= pos_d;
		end
	end

	assign cell_num = CELL_W'(pos_s4.r * cfg.col_count) + CELL_W'(pos_s4.c) + CELL_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			rsp_s5.cell_number  <= pos_s4.invalid ? '0 : cell_num;
			rsp_s5.step_invalid <= pos_s4.invalid;
		end
	end

	assign rsp = rsp_s5;

endmodule

### sv/sgci_checker.sv
// ----------------------------------------------------------------------------
// sgci_checker
// port-level checks on the serpentine grid index block
// ----------------------------------------------------------------------------
`include "serpentine_grid_cell_index_core_macros.svh"

module sgci_checker
	import sgci_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	`SGCI_ASSERT_NOW(a_invalid_zero, rsp_valid && rsp.step_invalid, rsp.cell_number == '0)
	`SGCI_ASSERT_NOW(a_valid_nonzero, rsp_valid && !rsp.step_invalid, rsp.cell_number != '0)
	`SGCI_ASSERT_NOW(a_ready_when_drained, !rsp_valid, req_ready)
	`SGCI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind serpentine_grid_cell_index_core sgci_checker u_sgci_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
